[sv/edd_pkg.sv]
`default_nettype none
package edd_pkg;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LEVELS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  // mode codes
  localparam logic [2:0] MODE_PASS       = 3'd0;
  localparam logic [2:0] MODE_GREY       = 3'd1;
  localparam logic [2:0] MODE_POST_COLOR = 3'd2;
  localparam logic [2:0] MODE_POST_GREY  = 3'd3;
  localparam logic [2:0] MODE_FS_COLOR   = 3'd4;
  localparam logic [2:0] MODE_FS_GREY    = 3'd5;
  localparam logic [2:0] MODE_ATK_GREY   = 3'd6;

  localparam int MAX_WIDTH_DEF = 1024;

  // reset values of the registers
  localparam logic [2:0]  MODE_RST   = MODE_PASS;
  localparam logic [4:0]  LEVELS_RST = 5'd2;
  localparam logic [10:0] WIDTH_RST  = 11'd900;

  // input and result items
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // saturate to the signed 10 bit error range
  function automatic logic signed [9:0] sat_err(input logic signed [11:0] v);
    logic signed [9:0] r;
    if (v < -12'sd512) r = -10'sd512;
    else if (v > 12'sd511) r = 10'sd511;
    else r = v[9:0];
    return r;
  endfunction

  // saturate to a pixel value
  function automatic logic [7:0] sat_pix(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // output step floor(255/levels) for levels 1..16
  function automatic logic [7:0] quant_step(input logic [4:0] lv);
    logic [7:0] r;
    case (lv)
      5'd1:    r = 8'd255;
      5'd2:    r = 8'd127;
      5'd3:    r = 8'd85;
      5'd4:    r = 8'd63;
      5'd5:    r = 8'd51;
      5'd6:    r = 8'd42;
      5'd7:    r = 8'd36;
      5'd8:    r = 8'd31;
      5'd9:    r = 8'd28;
      5'd10:   r = 8'd25;
      5'd11:   r = 8'd23;
      5'd12:   r = 8'd21;
      5'd13:   r = 8'd19;
      5'd14:   r = 8'd18;
      5'd15:   r = 8'd17;
      default: r = 8'd15;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/edd_in_if.sv]
`default_nettype none
interface edd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_start, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input frame_start, output ready);
endinterface
`default_nettype wire

[sv/edd_out_if.sv]
`default_nettype none
interface edd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface
`default_nettype wire

[sv/edd_cfg_if.sv]
`default_nettype none
interface edd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/edd_ram.sv]
`default_nettype none
module edd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[sv/error_diffusion_dither.sv]
// channel | dir | handshake   | payload
// pix_i   | in  | valid/ready | red_in, green_in, blue_in, frame_start
// pix_o   | out | valid/ready | red_out, green_out, blue_out
// cfg_i   | in  | valid/ready | index (0 mode, 1 levels, 2 width), data
//
// one item at a time: accept, then the states read, E1 to E4 and write back;
// at the end of a row FL0, FL1 write back the pending lower-row error entries
// the states run the arithmetic chain luma, error add, quantise and
// diffuse, each stage registered, around one read-modify-write of the stores
// reset and a frame_start item each run a clearing pass over all MAX_WIDTH
// entries of both error stores; no item is taken during reset's pass
// a result waits in the output register; the next item is accepted as it leaves
`default_nettype none
module error_diffusion_dither #(
  parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  edd_in_if.sink    pix_i,
  edd_out_if.source pix_o,
  edd_cfg_if.sink   cfg_i
);
  import edd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = 30;

  // luma weights, Q0.16
  localparam logic [23:0] LUMA_R = 24'd13933;
  localparam logic [23:0] LUMA_G = 24'd46871;
  localparam logic [23:0] LUMA_B = 24'd4732;
  // n / 510 as (n * RECIP) >> RECIP_SH, exact for n below 8416
  localparam logic [27:0] RECIP    = 28'd8225;
  localparam int          RECIP_SH = 22;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_FL0  = 4'd2;
  localparam logic [3:0] S_FL1  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_E1   = 4'd5;
  localparam logic [3:0] S_E2   = 4'd6;
  localparam logic [3:0] S_E3   = 4'd7;
  localparam logic [3:0] S_E4   = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;

  // configuration registers
  logic [2:0]  mode_q;
  logic [4:0]  levels_q;
  logic [10:0] width_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RST;
      levels_q <= LEVELS_RST;
      width_q  <= WIDTH_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MODE:   mode_q   <= cfg_i.data[2:0];
        REG_LEVELS: levels_q <= cfg_i.data[4:0];
        REG_WIDTH:  width_q  <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // clamped width and levels
  logic [CW-1:0] w_c;
  logic [4:0]    lv_c;
  logic [7:0]    step_c;

  always_comb begin
    if (width_q == '0) w_c = CW'(1);
    else if (int'(width_q) > MAX_WIDTH) w_c = CW'(MAX_WIDTH);
    else w_c = CW'(width_q);
    if (levels_q == '0) lv_c = 5'd1;
    else if (levels_q > 5'd16) lv_c = 5'd16;
    else lv_c = levels_q;
    step_c = quant_step(lv_c);
  end

  // mode decode
  logic grey, quant, diffuse, atk;

  always_comb begin
    grey = 1'b0; quant = 1'b0; diffuse = 1'b0; atk = 1'b0;
    unique case (mode_q) inside
      MODE_GREY:                   grey = 1'b1;
      MODE_POST_COLOR:             quant = 1'b1;
      MODE_POST_GREY:              begin grey = 1'b1; quant = 1'b1; end
      MODE_FS_COLOR:               begin quant = 1'b1; diffuse = 1'b1; end
      MODE_FS_GREY:                begin grey = 1'b1; quant = 1'b1; diffuse = 1'b1; end
      MODE_ATK_GREY:               begin
        grey = 1'b1; quant = 1'b1; diffuse = 1'b1; atk = 1'b1;
      end
      default:                     ;
    endcase
  end

  // sequencer and datapath registers
  logic [3:0]    state_q, state_d;
  logic          ret_rd_q, ret_rd_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] col_q, col_d;
  logic          par_q, par_d;
  logic          c1v_q, c1v_d;
  logic          out_valid_q, out_valid_d;

  logic signed [9:0] a1_q [3];
  logic signed [9:0] a1_d [3];
  logic signed [9:0] a2_q [3];
  logic signed [9:0] a2_d [3];
  logic signed [9:0] pm_q [3];
  logic signed [9:0] pm_d [3];
  logic signed [9:0] c1_q [3];
  logic signed [9:0] c1_d [3];

  pix_in_t  px_q;
  pix_out_t out_q, out_d;
  logic [7:0]        base_q [3];
  logic [7:0]        v_q    [3];
  logic [13:0]       n_q    [3];
  logic [4:0]        idx_q  [3];
  logic [7:0]        q_q    [3];
  logic signed [8:0] e_q    [3];
  logic [EW-1:0]     init_q;

  logic accept;
  assign accept = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == S_IDLE) && (!out_valid_q || pix_o.ready);

  // store ports
  logic [EW-1:0] rd0, rd1, cur_rd, nxt_rd;
  logic          we0, we1, cur_we, nxt_we;
  logic [AW-1:0] wa0, wa1, cur_wa, nxt_wa;
  logic [EW-1:0] wd0, wd1, cur_wd, nxt_wd;
  logic [CW-1:0] colm1;
  logic [CW-1:0] colp1;

  assign colm1  = col_q - CW'(1);
  assign colp1  = col_q + CW'(1);
  assign cur_rd = par_q ? rd1 : rd0;
  assign nxt_rd = par_q ? rd0 : rd1;

  always_comb begin
    if (state_q == S_CLR) begin
      we0 = 1'b1; we1 = 1'b1;
      wa0 = clr_q; wa1 = clr_q;
      wd0 = '0;   wd1 = '0;
    end else begin
      we0 = par_q ? nxt_we : cur_we;
      we1 = par_q ? cur_we : nxt_we;
      wa0 = par_q ? nxt_wa : cur_wa;
      wa1 = par_q ? cur_wa : nxt_wa;
      wd0 = par_q ? nxt_wd : cur_wd;
      wd1 = par_q ? cur_wd : nxt_wd;
    end
  end

  edd_ram #(.WIDTH(EW), .DEPTH(MAX_WIDTH)) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wa0),
    .wdata_i (wd0),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (rd0)
  );

  edd_ram #(.WIDTH(EW), .DEPTH(MAX_WIDTH)) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wa1),
    .wdata_i (wd1),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (rd1)
  );

  // luma of the latched pixel
  logic [23:0] luma_sum;
  assign luma_sum = LUMA_R * 24'(px_q.red_in) + LUMA_G * 24'(px_q.green_in)
                  + LUMA_B * 24'(px_q.blue_in);

  // arithmetic of each stage
  logic [7:0]        base_d [3];
  logic [7:0]        v_d    [3];
  logic [13:0]       n_d    [3];
  logic [4:0]        idx_d  [3];
  logic [7:0]        q_d    [3];
  logic signed [8:0] e_d    [3];
  logic [27:0]       prod   [3];
  logic [12:0]       qprod  [3];

  always_comb begin
    logic signed [11:0] sum;
    logic signed [9:0]  cerr;
    logic signed [9:0]  aerr;
    for (int c = 0; c < 3; c++) begin
      base_d[c] = grey ? luma_sum[23:16]
                : (c == 0) ? px_q.red_in : (c == 1) ? px_q.green_in : px_q.blue_in;
      cerr = grey ? $signed(cur_rd[9:0]) : $signed(cur_rd[10*c +: 10]);
      aerr = grey ? a1_q[0] : a1_q[c];
      sum  = $signed({4'b0, base_q[c]}) + 12'(cerr) + 12'(aerr);
      v_d[c]   = diffuse ? sat_pix(sum) : base_q[c];
      n_d[c]   = ({8'b0, lv_c, 1'b0} * {6'b0, v_q[c]}) + 14'd255;
      prod[c]  = 28'(n_q[c]) * RECIP;
      idx_d[c] = 5'(prod[c] >> RECIP_SH);
      qprod[c] = 13'(idx_q[c]) * 13'(step_c);
      q_d[c]   = quant ? qprod[c][7:0] : v_q[c];
      e_d[c]   = diffuse ? ($signed({1'b0, v_q[c]}) - $signed({1'b0, q_d[c]})) : 9'sd0;
    end
  end

  // error spreading at write back
  logic signed [9:0] far_v [3];
  logic signed [9:0] nx_v  [3];
  logic signed [9:0] k3_v  [3];
  logic signed [9:0] k7_v  [3];

  always_comb begin
    logic signed [11:0] e12;
    logic signed [11:0] k7, k3, k5, k1, far;
    logic signed [9:0]  s1;
    cur_wd = '0;
    nxt_wd = '0;
    for (int c = 0; c < 3; c++) begin
      e12 = 12'(e_q[c]);
      if (atk) begin
        k7 = e12 >>> 3; k3 = k7; k5 = k7; k1 = k7; far = k7;
      end else begin
        k7  = (e12 * 12'sd7) >>> 4;
        k3  = (e12 * 12'sd3) >>> 4;
        k5  = (e12 * 12'sd5) >>> 4;
        k1  = e12 >>> 4;
        far = 12'sd0;
      end
      far_v[c] = sat_err(far);
      k7_v[c]  = sat_err(12'(a2_q[c]) + k7);
      k3_v[c]  = sat_err(12'(pm_q[c]) + k3);
      s1       = sat_err(12'($signed(init_q[10*c +: 10])) + (c1v_q ? 12'(c1_q[c]) : 12'sd0));
      nx_v[c]  = sat_err(12'(s1) + k5);
      c1_d[c]  = sat_err(k1);
      cur_wd[10*c +: 10] = far_v[c];
      if (state_q == S_WB) nxt_wd[10*c +: 10] = k3_v[c];
      else if (state_q == S_FL0) nxt_wd[10*c +: 10] = pm_q[c];
      else nxt_wd[10*c +: 10] = sat_err(12'($signed(nxt_rd[10*c +: 10])) + 12'(c1_q[c]));
    end
  end

  // store write selection
  always_comb begin
    cur_we = (state_q == S_WB);
    cur_wa = col_q[AW-1:0];
    nxt_we = 1'b0;
    nxt_wa = colm1[AW-1:0];
    unique case (state_q)
      S_WB:    nxt_we = (col_q != '0);
      S_FL0:   nxt_we = 1'b1;
      S_FL1:   begin nxt_we = c1v_q; nxt_wa = col_q[AW-1:0]; end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_rd_d    = ret_rd_q;
    clr_d       = clr_q;
    col_d       = col_q;
    par_d       = par_q;
    c1v_d       = c1v_q;
    out_valid_d = out_valid_q && !pix_o.ready;
    out_d       = out_q;
    for (int c = 0; c < 3; c++) begin
      a1_d[c] = a1_q[c];
      a2_d[c] = a2_q[c];
      pm_d[c] = pm_q[c];
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ret_rd_d = 1'b1;
          clr_d    = '0;
          if (pix_i.frame_start) state_d = S_CLR;
          else if (col_q >= w_c) state_d = S_FL0;
          else state_d = S_RD;
        end
      end
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_WIDTH - 1)) begin
          col_d = '0;
          par_d = 1'b0;
          c1v_d = 1'b0;
          for (int c = 0; c < 3; c++) begin
            a1_d[c] = '0;
            a2_d[c] = '0;
          end
          state_d = ret_rd_q ? S_RD : S_IDLE;
        end
      end
      S_FL0: state_d = S_FL1;
      S_FL1: begin
        col_d = '0;
        par_d = !par_q;
        c1v_d = 1'b0;
        for (int c = 0; c < 3; c++) begin
          a1_d[c] = '0;
          a2_d[c] = '0;
        end
        state_d = ret_rd_q ? S_RD : S_IDLE;
      end
      S_RD: state_d = S_E1;
      S_E1: state_d = S_E2;
      S_E2: state_d = S_E3;
      S_E3: state_d = S_E4;
      S_E4: state_d = S_WB;
      S_WB: begin
        for (int c = 0; c < 3; c++) begin
          a1_d[c] = k7_v[c];
          a2_d[c] = far_v[c];
          pm_d[c] = nx_v[c];
        end
        c1v_d       = (colp1 < w_c);
        col_d       = colp1;
        out_valid_d = 1'b1;
        out_d       = '{red_out: q_q[0], green_out: q_q[1], blue_out: q_q[2]};
        if (colp1 >= w_c) begin
          ret_rd_d = 1'b0;
          state_d  = S_FL0;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_rd_q    <= 1'b0;
      clr_q       <= '0;
      col_q       <= '0;
      par_q       <= 1'b0;
      c1v_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        a1_q[c] <= '0;
        a2_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ret_rd_q    <= ret_rd_d;
      clr_q       <= clr_d;
      col_q       <= col_d;
      par_q       <= par_d;
      c1v_q       <= c1v_d;
      out_valid_q <= out_valid_d;
      for (int c = 0; c < 3; c++) begin
        a1_q[c] <= a1_d[c];
        a2_q[c] <= a2_d[c];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= '{red_in: pix_i.red_in, green_in: pix_i.green_in,
                blue_in: pix_i.blue_in, frame_start: pix_i.frame_start};
    end
    if (state_q == S_E1) init_q <= nxt_rd;
    if (state_q == S_WB) begin
      for (int c = 0; c < 3; c++) begin
        c1_q[c] <= c1_d[c];
      end
    end
    out_q <= out_d;
    for (int c = 0; c < 3; c++) begin
      pm_q[c] <= pm_d[c];
      if (state_q == S_RD) base_q[c] <= base_d[c];
      if (state_q == S_E1) v_q[c] <= v_d[c];
      if (state_q == S_E2) n_q[c] <= n_d[c];
      if (state_q == S_E3) idx_q[c] <= idx_d[c];
      if (state_q == S_E4) begin
        q_q[c] <= q_d[c];
        e_q[c] <= e_d[c];
      end
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.red_out   = out_q.red_out;
  assign pix_o.green_out = out_q.green_out;
  assign pix_o.blue_out  = out_q.blue_out;

  // a result only appears from write back
  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WB))
    else $error("result without write back");

  // the pixel being written always lies inside the row
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (col_q < w_c))
    else $error("column outside the row at write back");

  // a frame start item always runs the clearing pass
  a_fs_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pix_i.frame_start) |=> (state_q == S_CLR))
    else $error("frame start without clearing pass");

  // no new item while a pixel is in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E1) |-> !pix_i.ready)
    else $error("ready while a pixel is in flight");

endmodule
`default_nettype wire

[test/edd_tb_if.sv]
`timescale 1ns / 100ps
`default_nettype none
// types shared by the bench; the block's own interfaces carry the items
package edd_tb_types;
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } dither_pix_t;
endpackage
`default_nettype wire

[test/error_diffusion_dither_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module error_diffusion_dither_tb;
  import edd_pkg::*;
  import edd_tb_types::*;

  localparam int WIDTH_MAX = MAX_WIDTH_DEF;
  localparam int STALL_LIMIT = 20000;

  // dither model with its own error stores and configuration
  class dither_scoreboard;
    int row_err_a[WIDTH_MAX][3];
    int row_err_b[WIDTH_MAX][3];
    int ahead1[3];
    int ahead2[3];
    int col;
    bit parity;
    logic [2:0] mode;
    logic [4:0] levels;
    logic [10:0] width;
    dither_pix_t expected_pix[$];
    int fail_count;

    function new();
      clear_stores();
      col = 0;
      parity = 0;
      mode = MODE_RST;
      levels = LEVELS_RST;
      width = WIDTH_RST;
      fail_count = 0;
    endfunction

    function void clear_stores();
      for (int i = 0; i < WIDTH_MAX; i++) begin
        for (int c = 0; c < 3; c++) begin
          row_err_a[i][c] = 0;
          row_err_b[i][c] = 0;
        end
      end
      for (int c = 0; c < 3; c++) begin
        ahead1[c] = 0;
        ahead2[c] = 0;
      end
    endfunction

    function int clip_err(int v);
      if (v < -512) return -512;
      if (v > 511) return 511;
      return v;
    endfunction

    function int clip_pix(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    // arithmetic shift floors toward minus infinity
    function int floor_div(int v, int s);
      return v >>> s;
    endfunction

    function void row_end();
      col = 0;
      parity = ~parity;
      for (int c = 0; c < 3; c++) begin
        ahead1[c] = 0;
        ahead2[c] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        REG_MODE: mode = data[2:0];
        REG_LEVELS: levels = data[4:0];
        REG_WIDTH: width = data;
        default: ;
      endcase
    endfunction

    function int cur_get(int x, int c);
      return parity ? row_err_b[x][c] : row_err_a[x][c];
    endfunction

    function void cur_set(int x, int c, int v);
      if (parity) row_err_b[x][c] = v;
      else row_err_a[x][c] = v;
    endfunction

    function void nxt_add(int x, int c, int v);
      if (parity) row_err_a[x][c] = clip_err(row_err_a[x][c] + v);
      else row_err_b[x][c] = clip_err(row_err_b[x][c] + v);
    endfunction

    // note an accepted input item and queue its expected pixel
    function void note_pixel(pix_in_t p);
      int w, lv, x, luma, step;
      int base[3], v[3], q[3], e[3];
      int k7, k3, k5, k1, far;
      bit grey, quant, diffuse, atk;
      dither_pix_t r;
      if (p.frame_start) begin
        clear_stores();
        col = 0;
        parity = 0;
      end
      w = int'(width);
      if (w < 1) w = 1;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      lv = int'(levels);
      if (lv < 1) lv = 1;
      if (lv > 16) lv = 16;
      if (col >= w) row_end();
      x = col;
      grey = mode inside {MODE_GREY, MODE_POST_GREY, MODE_FS_GREY, MODE_ATK_GREY};
      quant = mode >= MODE_POST_COLOR && mode <= MODE_ATK_GREY;
      diffuse = mode >= MODE_FS_COLOR && mode <= MODE_ATK_GREY;
      atk = mode == MODE_ATK_GREY;
      base[0] = int'(p.red_in);
      base[1] = int'(p.green_in);
      base[2] = int'(p.blue_in);
      if (grey) begin
        luma = (13933 * base[0] + 46871 * base[1] + 4732 * base[2]) >> 16;
        base[0] = luma;
        base[1] = luma;
        base[2] = luma;
      end
      step = 255 / lv;
      for (int c = 0; c < 3; c++) begin
        int ec;
        ec = grey ? 0 : c;
        v[c] = diffuse ? clip_pix(base[c] + cur_get(x, ec) + ahead1[ec]) : base[c];
        q[c] = quant ? ((2 * lv * v[c] + 255) / 510) * step : v[c];
        e[c] = diffuse ? v[c] - q[c] : 0;
      end
      if (grey) begin
        e[1] = e[0];
        e[2] = e[0];
      end
      // spread the error forward
      for (int c = 0; c < 3; c++) begin
        if (atk) begin
          far = floor_div(e[c], 3);
          k7 = far;
          k3 = far;
          k5 = far;
          k1 = far;
        end else begin
          k7 = floor_div(7 * e[c], 4);
          k3 = floor_div(3 * e[c], 4);
          k5 = floor_div(5 * e[c], 4);
          k1 = floor_div(e[c], 4);
          far = 0;
        end
        ahead1[c] = clip_err(ahead2[c] + k7);
        ahead2[c] = clip_err(far);
        cur_set(x, c, clip_err(far));
        if (x >= 1) nxt_add(x - 1, c, k3);
        nxt_add(x, c, k5);
        if (x + 1 < w) nxt_add(x + 1, c, k1);
      end
      r.red = q[0][7:0];
      r.green = q[1][7:0];
      r.blue = q[2][7:0];
      expected_pix.push_back(r);
      col = x + 1;
      if (col >= w) row_end();
    endfunction

    // compare a result item with the oldest expected pixel
    function void check_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      dither_pix_t r;
      if (expected_pix.size() == 0) begin
        $error("unexpected result item red %0d green %0d blue %0d", red, green, blue);
        fail_count++;
        return;
      end
      r = expected_pix.pop_front();
      if (red !== r.red) begin
        $error("red_out expected %0d actual %0d", r.red, red);
        fail_count++;
      end
      if (green !== r.green) begin
        $error("green_out expected %0d actual %0d", r.green, green);
        fail_count++;
      end
      if (blue !== r.blue) begin
        $error("blue_out expected %0d actual %0d", r.blue, blue);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  edd_in_if pix_in();
  edd_out_if pix_out();
  edd_cfg_if cfg();

  error_diffusion_dither i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix_in.sink),
    .pix_o (pix_out.source),
    .cfg_i (cfg.sink)
  );

  dither_scoreboard dither_sb;
  bit quiet;
  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watch all three channels on every edge
  always @(posedge clk) begin
    if (rst_n && pix_in.valid && pix_in.ready) begin
      pix_in_t p;
      p.red_in = pix_in.red_in;
      p.green_in = pix_in.green_in;
      p.blue_in = pix_in.blue_in;
      p.frame_start = pix_in.frame_start;
      dither_sb.note_pixel(p);
    end
    if (rst_n && pix_out.valid && pix_out.ready)
      dither_sb.check_pixel(pix_out.red_out, pix_out.green_out, pix_out.blue_out);
    if (rst_n && cfg.valid && cfg.ready) dither_sb.write_reg(cfg.index, cfg.data);
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // watchdog
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // result side stalls in random bursts
  initial begin
    pix_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pix_out.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        pix_out.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic start);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= red;
    pix_in.green_in <= green;
    pix_in.blue_in <= blue;
    pix_in.frame_start <= start;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // valid stays high across back to back writes; the caller lowers it
  task automatic write_cfg(logic [1:0] idx, logic [10:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // wait until every expected pixel has come out, plus the block's tail
  task automatic drain();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (dither_sb.expected_pix.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic [2:0] m, logic [4:0] lv, logic [10:0] w);
    drain();
    write_cfg(REG_MODE, {8'd0, m});
    write_cfg(REG_LEVELS, {6'd0, lv});
    write_cfg(REG_WIDTH, w);
    cfg.valid <= 1'b0;
  endtask

  // a frame of random pixels, mostly smooth ramps to exercise diffusion, all noise when noisy
  task automatic send_frame(int count, bit noisy);
    int level;
    level = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      logic [7:0] r, g, b;
      if (noisy || $urandom_range(0, 4) == 0) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end else begin
        level = (level + $urandom_range(0, 6)) % 256;
        r = 8'(level);
        g = 8'(level ^ $urandom_range(0, 3));
        b = 8'(255 - level);
      end
      send_pixel(r, g, b, i == 0 || $urandom_range(0, 299) == 0);
    end
  endtask

  initial begin
    logic [2:0] m;
    logic [10:0] w;
    logic [4:0] lv;
    dither_sb = new();
    quiet = 1'b0;
    idle_cycles = 0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.frame_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_MODE;
    cfg.data = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes under reset settings, then each mode on a tiny frame
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hFF, 1'b0);
    setup(MODE_GREY, 5'd0, 11'd2);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd1, 1'b0);
    setup(MODE_POST_COLOR, 5'd31, 11'd3);
    send_pixel(8'd127, 8'd128, 8'd255, 1'b1);
    setup(MODE_POST_GREY, 5'd1, 11'd3);
    send_pixel(8'd200, 8'd50, 8'd10, 1'b0);
    setup(MODE_FS_COLOR, 5'd2, 11'd3);
    for (int i = 0; i < 6; i++) send_pixel(8'd100, 8'd160, 8'd250, i == 0);
    setup(MODE_FS_GREY, 5'd16, 11'd2);
    for (int i = 0; i < 4; i++) send_pixel(8'd90, 8'd90, 8'd90, i == 0);
    setup(MODE_ATK_GREY, 5'd3, 11'd4);
    for (int i = 0; i < 5; i++) send_pixel(8'd60, 8'd70, 8'd80, i == 0);
    // width shrunk mid-row, unused mode seven and out-of-range width
    setup(3'd7, 5'd4, 11'd3);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    setup(MODE_FS_COLOR, 5'd4, 11'd0);
    send_pixel(8'd33, 8'd44, 8'd55, 1'b0);
    send_pixel(8'd200, 8'd44, 8'd55, 1'b0);
    setup(MODE_ATK_GREY, 5'd2, 11'd2047);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);

    // random phases with varied settings, mostly narrow images
    for (int ph = 0; ph < 24; ph++) begin
      m = 3'($urandom_range(0, 7));
      if (m < 3'd4 && $urandom_range(0, 1)) m = m + 3'd4;
      if (ph == 0) m = MODE_ATK_GREY;
      lv = (ph % 6 == 0) ? 5'd16 : (ph % 6 == 1) ? 5'd1 : 5'($urandom_range(0, 31));
      if (ph == 3) w = 11'd1024;
      else if (ph == 4) w = 11'd2;
      else w = 11'($urandom_range(2, 24));
      setup(m, lv, w);
      if (ph >= 20) quiet = 1'b1;
      send_frame(ph == 3 ? 1050 : $urandom_range(10, 50), ph % 5 == 4);
    end

    drain();
    if (dither_sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
